// ===== design/mhr_pkg.sv =====
// Shared types and constants for the measurement history ring.
`default_nettype none
package mhr_pkg;

	// Widest record the block carries on its ports
	localparam int MAX_WORDS = 10;
	localparam int WORD_W    = 32;
	localparam int IDX_W     = 4;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [MAX_WORDS-1:0] rec_t;

	// Command codes
	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_DUMP   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	// Tag that travels with each memory read
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] widx;
		logic             last_word;
		logic             last_rec;
	} rd_tag_t;

endpackage
`default_nettype wire

// ===== design/mhr_store.sv =====
// Record memory: one write port, one read port with registered read data.
`default_nettype none
module mhr_store #(
	parameter int DEPTH = 20,
	parameter int WORDS = 10,
	parameter int MW    = DEPTH * WORDS,
	parameter int AW    = (MW > 1) ? $clog2(MW) : 1
) (
	input  wire              clk,
	input  wire              wr_en,
	input  wire  [AW-1:0]    wr_addr,
	input  mhr_pkg::word_t   wr_data,
	input  wire              rd_en,
	input  wire  [AW-1:0]    rd_addr,
	output mhr_pkg::word_t   rd_data
);
	import mhr_pkg::*;

	word_t mem_q [MW];
	word_t rd_data_q;

	// Write one word per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read one word per cycle, data registered for the next cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ===== design/mhr_seq.sv =====
// Command sequencer: pointers, record count and word-by-word memory access.
`default_nettype none
module mhr_seq #(
	parameter int DEPTH = 20,
	parameter int WORDS = 10,
	parameter int MW    = DEPTH * WORDS,
	parameter int AW    = (MW > 1) ? $clog2(MW) : 1
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire  [1:0]        operation,
	input  mhr_pkg::rec_t     meas,
	output logic              busy,
	output logic              wr_en,
	output mhr_pkg::word_t    wr_data,
	output logic              rd_en,
	output logic [AW-1:0]     mem_addr,
	output mhr_pkg::rd_tag_t  tag
);
	import mhr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_APPEND = 3'b010,
		S_DUMP   = 3'b100
	} state_t;

	state_t          state_q;
	logic [PW-1:0]   wp_q;
	logic [CW-1:0]   cnt_q;
	logic [PW-1:0]   slot_q;
	logic [CW-1:0]   rem_q;
	logic [WW-1:0]   w_q;
	rec_t            meas_q;

	logic            accept;
	logic            last_word;
	logic            last_rec;
	logic [PW-1:0]   wp_prev;
	logic [PW-1:0]   slot_prev;
	logic [PW-1:0]   slot_next;

	// Decode handshake and wrap points
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign last_word = (w_q == WW'(WORDS - 1));
	assign last_rec  = (rem_q == CW'(1));
	assign wp_prev   = (wp_q == '0) ? PW'(DEPTH - 1) : wp_q - PW'(1);
	assign slot_prev = (slot_q == '0) ? PW'(DEPTH - 1) : slot_q - PW'(1);
	assign slot_next = (slot_q == PW'(DEPTH - 1)) ? '0 : slot_q + PW'(1);

	// Drive the memory port from the current slot and word
	assign wr_en    = (state_q == S_APPEND);
	assign rd_en    = (state_q == S_DUMP);
	assign wr_data  = meas_q[0];
	assign mem_addr = AW'(slot_q) * AW'(WORDS) + AW'(w_q);

	// Tag each read beat so the collector can rebuild the record
	always_comb begin
		tag           = '0;
		tag.vld       = rd_en;
		tag.widx      = IDX_W'(w_q);
		tag.last_word = last_word;
		tag.last_rec  = last_rec;
	end

	// Step through commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wp_q    <= '0;
			cnt_q   <= '0;
			slot_q  <= '0;
			rem_q   <= '0;
			w_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (operation)
							OP_APPEND: begin
								slot_q  <= wp_q;
								w_q     <= '0;
								state_q <= S_APPEND;
							end
							OP_DUMP: begin
								if (cnt_q != '0) begin
									slot_q  <= wp_prev;
									rem_q   <= cnt_q;
									w_q     <= '0;
									state_q <= S_DUMP;
								end
							end
							OP_CLEAR: begin
								wp_q  <= '0;
								cnt_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_APPEND: begin
					if (last_word) begin
						state_q <= S_IDLE;
						wp_q    <= slot_next;
						if (cnt_q != CW'(DEPTH)) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end else begin
						w_q <= w_q + WW'(1);
					end
				end
				S_DUMP: begin
					if (last_word) begin
						w_q    <= '0;
						slot_q <= slot_prev;
						rem_q  <= rem_q - CW'(1);
						if (last_rec) begin
							state_q <= S_IDLE;
						end
					end else begin
						w_q <= w_q + WW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the appended record, shift one word out per write beat
	always_ff @(posedge clk) begin
		if (accept) begin
			meas_q <= meas;
		end else if (state_q == S_APPEND) begin
			meas_q <= meas_q >> WORD_W;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("record count beyond depth");
	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q < PW'(DEPTH) || DEPTH == (1 << PW))
		else $error("write pointer beyond depth");
	a_dump_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> (rem_q != '0 && rem_q <= cnt_q))
		else $error("dump walks more records than held");
	a_append_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPEND && last_word) |=> (cnt_q != '0))
		else $error("append left the store empty");
`endif

endmodule
`default_nettype wire

// ===== design/mhr_collect.sv =====
// Record collector: gathers read words into a record and strobes it out.
`default_nettype none
module mhr_collect #(
	parameter int WORDS = 10
) (
	input  wire               clk,
	input  wire               arst_n,
	input  mhr_pkg::rd_tag_t  tag,
	input  mhr_pkg::word_t    rd_data,
	output logic              valid,
	output mhr_pkg::rec_t     words,
	output logic              is_last
);
	import mhr_pkg::*;

	rd_tag_t tag_s1;
	rec_t    asm_q;
	rec_t    out_q;
	logic    valid_q;
	logic    last_q;

	// Align the tag with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1  <= '0;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			tag_s1  <= tag;
			valid_q <= tag_s1.vld && tag_s1.last_word;
			if (tag_s1.vld && tag_s1.last_word) begin
				last_q <= tag_s1.last_rec;
			end
		end
	end

	// Assemble words; on the last word, publish the whole record
	always_ff @(posedge clk) begin
		if (tag_s1.vld) begin
			for (int j = 0; j < MAX_WORDS; j++) begin
				if (IDX_W'(j) == tag_s1.widx) begin
					asm_q[j] <= rd_data;
				end
			end
			if (tag_s1.last_word) begin
				for (int j = 0; j < MAX_WORDS; j++) begin
					if (j >= WORDS) begin
						out_q[j] <= '0;
					end else if (IDX_W'(j) == tag_s1.widx) begin
						out_q[j] <= rd_data;
					end else begin
						out_q[j] <= asm_q[j];
					end
				end
			end
		end
	end

	assign valid   = valid_q;
	assign words   = out_q;
	assign is_last = last_q;

endmodule
`default_nettype wire

// ===== design/measurement_history_ring_core.sv =====
// Top level of the measurement history ring.
//
// Command channel: an item is taken at a rising edge with start high and
// busy low. operation selects append (0), dump newest first (1) or clear (2);
// code 3 is ignored. measurement_0..9 carry the record of an append.
// Result channel: each dumped record shows on word_0..9 and is_last for one
// cycle, flagged by valid; the receiver cannot hold results off.
// Append: busy while the record is written, one word per cycle, into the
// single record memory; a new command is taken only once busy drops.
// Dump: busy while the records are read, one word read per cycle; each
// record strobes after its last word passes the read-data register and
// the collector output register, the last (is_last high) after busy drops.
// An empty store gives no beat and busy stays low.
// Clear: busy stays low, pointer and count go to zero. A dump only walks
// slots appended since the last clear, so the memory needs no wipe pass.
// Reset: pointer and count zero, store empty, no result pending.
`default_nettype none
module measurement_history_ring_core #(
	parameter int DEPTH = 20,
	parameter int WORDS = 10
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  operation,
	input  wire  [31:0] measurement_0,
	input  wire  [31:0] measurement_1,
	input  wire  [31:0] measurement_2,
	input  wire  [31:0] measurement_3,
	input  wire  [31:0] measurement_4,
	input  wire  [31:0] measurement_5,
	input  wire  [31:0] measurement_6,
	input  wire  [31:0] measurement_7,
	input  wire  [31:0] measurement_8,
	input  wire  [31:0] measurement_9,
	output logic        valid,
	output logic [31:0] word_0,
	output logic [31:0] word_1,
	output logic [31:0] word_2,
	output logic [31:0] word_3,
	output logic [31:0] word_4,
	output logic [31:0] word_5,
	output logic [31:0] word_6,
	output logic [31:0] word_7,
	output logic [31:0] word_8,
	output logic [31:0] word_9,
	output logic        is_last
);
	import mhr_pkg::*;

	localparam int MW = DEPTH * WORDS;
	localparam int AW = (MW > 1) ? $clog2(MW) : 1;

	rec_t          meas;
	rec_t          out_words;
	logic          wr_en;
	logic          rd_en;
	word_t         wr_data;
	word_t         rd_data;
	logic [AW-1:0] mem_addr;
	rd_tag_t       tag;

	// Pack the command record
	assign meas = {measurement_9, measurement_8, measurement_7, measurement_6,
		measurement_5, measurement_4, measurement_3, measurement_2,
		measurement_1, measurement_0};

	mhr_seq #(
		.DEPTH (DEPTH),
		.WORDS (WORDS),
		.MW    (MW),
		.AW    (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.meas      (meas),
		.busy      (busy),
		.wr_en     (wr_en),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.mem_addr  (mem_addr),
		.tag       (tag)
	);

	mhr_store #(
		.DEPTH (DEPTH),
		.WORDS (WORDS),
		.MW    (MW),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (mem_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (mem_addr),
		.rd_data (rd_data)
	);

	mhr_collect #(
		.WORDS (WORDS)
	) u_collect (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag     (tag),
		.rd_data (rd_data),
		.valid   (valid),
		.words   (out_words),
		.is_last (is_last)
	);

	// Unpack the result record
	assign word_0 = out_words[0];
	assign word_1 = out_words[1];
	assign word_2 = out_words[2];
	assign word_3 = out_words[3];
	assign word_4 = out_words[4];
	assign word_5 = out_words[5];
	assign word_6 = out_words[6];
	assign word_7 = out_words[7];
	assign word_8 = out_words[8];
	assign word_9 = out_words[9];

endmodule
`default_nettype wire

// ===== bench/measurement_history_ring_core_tb.sv =====
// Testbench for measurement_history_ring_core: directed and random commands checked per beat.
`timescale 1ns / 100ps
module measurement_history_ring_core_tb;
	import mhr_pkg::*;

	localparam int DEPTH        = 20;
	localparam int WORDS        = 10;
	localparam int RESET_CYCLES = 4;
	localparam int TAIL_CYCLES  = WORDS + 4;
	localparam int LIMIT        = 500000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		rec_t words;
		logic last;
	} dump_beat_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	logic [1:0] operation = OP_APPEND;
	rec_t       meas      = '0;
	logic       busy;
	logic       valid;
	logic       is_last;
	logic [31:0] word_0, word_1, word_2, word_3, word_4;
	logic [31:0] word_5, word_6, word_7, word_8, word_9;
	rec_t       dumped;

	// Predicted ring contents and the beats still owed by the block
	rec_t       ring_words [DEPTH] = '{default: '0};
	int         ring_wr_ptr = 0;
	int         ring_count  = 0;
	dump_beat_t pending_beats [$];
	int         error_count   = 0;
	int         send_idle_pct = 0;
	int         cycle_count   = 0;

	assign dumped = {word_9, word_8, word_7, word_6, word_5,
		word_4, word_3, word_2, word_1, word_0};

	measurement_history_ring_core #(
		.DEPTH(DEPTH),
		.WORDS(WORDS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.measurement_0(meas[0]),
		.measurement_1(meas[1]),
		.measurement_2(meas[2]),
		.measurement_3(meas[3]),
		.measurement_4(meas[4]),
		.measurement_5(meas[5]),
		.measurement_6(meas[6]),
		.measurement_7(meas[7]),
		.measurement_8(meas[8]),
		.measurement_9(meas[9]),
		.valid(valid),
		.word_0(word_0),
		.word_1(word_1),
		.word_2(word_2),
		.word_3(word_3),
		.word_4(word_4),
		.word_5(word_5),
		.word_6(word_6),
		.word_7(word_7),
		.word_8(word_8),
		.word_9(word_9),
		.is_last(is_last)
	);

	// Free-running clock, 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("measurement_history_ring_core_tb: errors");
			$finish;
		end
	end

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		error_count++;
		$display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
	endtask

	// Apply one accepted command to the predicted ring, queue any dump beats
	function automatic void predict_command(logic [1:0] op, rec_t rec);
		rec_t       kept;
		int         slot;
		dump_beat_t beat;
		kept = '0;
		case (op)
			OP_APPEND: begin
				for (int w = 0; w < WORDS; w++)
					kept[w] = rec[w];
				ring_words[ring_wr_ptr] = kept;
				ring_wr_ptr = (ring_wr_ptr == DEPTH - 1) ? 0 : ring_wr_ptr + 1;
				if (ring_count < DEPTH)
					ring_count++;
			end
			OP_DUMP: begin
				slot = ring_wr_ptr;
				for (int k = 0; k < ring_count; k++) begin
					slot = (slot == 0) ? DEPTH - 1 : slot - 1;
					beat.words = ring_words[slot];
					beat.last  = (k == ring_count - 1);
					pending_beats = {pending_beats, beat};
				end
			end
			OP_CLEAR: begin
				foreach (ring_words[i])
					ring_words[i] = '0;
				ring_wr_ptr = 0;
				ring_count  = 0;
			end
			default: ;
		endcase
	endfunction

	// Check each result beat against the oldest expected one
	always @(posedge clk) begin
		dump_beat_t want;
		if (arst_n && valid) begin
			if (pending_beats.size() == 0) begin
				report_mismatch("unexpected beat, word_0", '0, dumped[0]);
			end else begin
				want = pending_beats.pop_front();
				for (int w = 0; w < MAX_WORDS; w++)
					if (dumped[w] !== want.words[w])
						report_mismatch($sformatf("word_%0d", w), want.words[w], dumped[w]);
				if (is_last !== want.last)
					report_mismatch("is_last", want.last, is_last);
			end
		end
	end

	function automatic word_t rand_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic rec_t rand_record();
		rec_t rec;
		for (int w = 0; w < MAX_WORDS; w++)
			rec[w] = rand_word();
		return rec;
	endfunction

	// Present one command, hold it until accepted, then predict it
	task automatic send_command(logic [1:0] op, rec_t rec);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		meas      <= rec;
		do @(posedge clk); while (busy);
		predict_command(op, rec);
	endtask

	// Drop start and hold until every expected beat has arrived
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_beats.size() != 0);
	endtask

	// Empty dumps, a single-record dump, an ignored code and a clear
	task automatic test_empty_and_single();
		send_idle_pct = 0;
		send_command(OP_DUMP, '0);
		send_command(OP_APPEND, '1);
		send_command(OP_UNUSED, rand_record());
		send_command(OP_DUMP, '0);
		send_command(OP_CLEAR, '1);
		send_command(OP_DUMP, '0);
	endtask

	// Overfill by one record so the pointer wraps and the oldest is lost
	task automatic test_full_wrap();
		rec_t rec;
		for (int i = 0; i <= DEPTH; i++) begin
			if (i == 1) begin
				for (int w = 0; w < MAX_WORDS; w++)
					rec[w] = w[0] ? 32'h5555_5555 : 32'hAAAA_AAAA;
			end else if (i == DEPTH) begin
				rec = '0;
			end else begin
				rec = rand_record();
			end
			send_command(OP_APPEND, rec);
		end
		send_command(OP_DUMP, '0);
	endtask

	// Let a dump finish completely, then issue the next commands back to back
	task automatic test_pause_until_drained();
		send_command(OP_CLEAR, '0);
		repeat (3) send_command(OP_APPEND, rand_record());
		send_command(OP_DUMP, '0);
		wait_drained();
		send_command(OP_DUMP, '0);
		send_command(OP_APPEND, rand_record());
		send_command(OP_DUMP, '0);
	endtask

	// Mostly appends and dumps, with occasional clears and ignored codes
	task automatic test_random_phase(int items, int idle_pct);
		int         sent;
		int         pick;
		logic [1:0] op;
		send_idle_pct = idle_pct;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(99);
			if (pick < 62)
				op = OP_APPEND;
			else if (pick < 86)
				op = OP_DUMP;
			else if (pick < 89)
				op = OP_CLEAR;
			else
				op = OP_UNUSED;
			send_command(op, rand_record());
			if (op != OP_UNUSED)
				sent++;
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_single();
		test_full_wrap();
		test_pause_until_drained();
		test_random_phase(75, 9);
		test_random_phase(75, 80);
		test_random_phase(70, 0);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("measurement_history_ring_core_tb: clean");
		else
			$display("measurement_history_ring_core_tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
design/mhr_pkg.sv
design/mhr_store.sv
design/mhr_seq.sv
design/mhr_collect.sv
design/measurement_history_ring_core.sv
bench/measurement_history_ring_core_tb.sv
